FILE: rtl/pbm_pkg.sv
package pbm_pkg;

  // Mode codes
  localparam logic [3:0] MODE_BLEND   = 4'd0;
  localparam logic [3:0] MODE_FILL    = 4'd1;
  localparam logic [3:0] MODE_GLASS   = 4'd2;
  localparam logic [3:0] MODE_DARKEN  = 4'd3;
  localparam logic [3:0] MODE_LIGHTEN = 4'd4;
  localparam logic [3:0] MODE_DIFF    = 4'd5;
  localparam logic [3:0] MODE_MULT    = 4'd6;
  localparam logic [3:0] MODE_SCREEN  = 4'd7;
  localparam logic [3:0] MODE_XOR     = 4'd8;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_WEIGHT     = 3'd1;
  localparam logic [2:0] REG_FILL_RED   = 3'd2;
  localparam logic [2:0] REG_FILL_GREEN = 3'd3;
  localparam logic [2:0] REG_FILL_BLUE  = 3'd4;
  localparam logic [2:0] REG_GLASS      = 3'd5;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned IN_W   = 88;
  localparam int unsigned OUT_W  = 32;

  localparam logic [8:0] FULL_WEIGHT = 9'd256;
  localparam logic [8:0] WEIGHT_RST  = 9'd256;

  typedef struct packed {
    logic [3:0]  mode;
    logic [8:0]  weight;
    logic [7:0]  fill_red;
    logic [7:0]  fill_green;
    logic [7:0]  fill_blue;
    logic [31:0] glass_color;
  } cfg_t;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] column;
    logic [31:0] dst_pixel;
    logic [31:0] src_pixel;
  } in_word_t;

endpackage

FILE: rtl/pbm_cfg_regs.sv
module pbm_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pbm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [pbm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pbm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output pbm_pkg::cfg_t               cfg
);

  pbm_pkg::cfg_t cfg_r;
  pbm_pkg::cfg_t cfg_nxt;
  logic [2:0]    idx;
  logic          wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[pbm_pkg::CFG_AW-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        pbm_pkg::REG_MODE:       cfg_nxt.mode        = cfg_pwdata[3:0];
        pbm_pkg::REG_WEIGHT:     cfg_nxt.weight      = cfg_pwdata[8:0];
        pbm_pkg::REG_FILL_RED:   cfg_nxt.fill_red    = cfg_pwdata[7:0];
        pbm_pkg::REG_FILL_GREEN: cfg_nxt.fill_green  = cfg_pwdata[7:0];
        pbm_pkg::REG_FILL_BLUE:  cfg_nxt.fill_blue   = cfg_pwdata[7:0];
        pbm_pkg::REG_GLASS:      cfg_nxt.glass_color = cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pbm_pkg::REG_MODE:       cfg_prdata = {28'd0, cfg_r.mode};
      pbm_pkg::REG_WEIGHT:     cfg_prdata = {23'd0, cfg_r.weight};
      pbm_pkg::REG_FILL_RED:   cfg_prdata = {24'd0, cfg_r.fill_red};
      pbm_pkg::REG_FILL_GREEN: cfg_prdata = {24'd0, cfg_r.fill_green};
      pbm_pkg::REG_FILL_BLUE:  cfg_prdata = {24'd0, cfg_r.fill_blue};
      pbm_pkg::REG_GLASS:      cfg_prdata = cfg_r.glass_color;
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= pbm_pkg::MODE_BLEND;
      cfg_r.weight      <= pbm_pkg::WEIGHT_RST;
      cfg_r.fill_red    <= '0;
      cfg_r.fill_green  <= '0;
      cfg_r.fill_blue   <= '0;
      cfg_r.glass_color <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/pbm_chan.sv
module pbm_chan (
  input  logic [3:0] mode,
  input  logic [7:0] s,
  input  logic [7:0] d,
  input  logic [8:0] w,
  output logic [7:0] r
);

  logic [8:0]  w_inv;
  logic [16:0] mix;
  logic [15:0] mul;
  logic [7:0]  s_inv;
  logic [7:0]  d_inv;
  logic [15:0] scr;

  assign w_inv = pbm_pkg::FULL_WEIGHT - w;
  // Weighted sum peaks at 255*256, so 17 bits hold it
  assign mix = (17'(s) * 17'(w)) + (17'(d) * 17'(w_inv));
  assign mul = 16'(s) * 16'(d);
  // 255 - x on a byte is its complement
  assign s_inv = ~s;
  assign d_inv = ~d;
  assign scr   = 16'(s_inv) * 16'(d_inv);

  always_comb begin
    case (mode)
      pbm_pkg::MODE_BLEND:   r = mix[15:8];
      pbm_pkg::MODE_DARKEN:  r = (s < d) ? s : d;
      pbm_pkg::MODE_LIGHTEN: r = (s > d) ? s : d;
      pbm_pkg::MODE_DIFF:    r = (s >= d) ? (s - d) : (d - s);
      pbm_pkg::MODE_MULT:    r = mul[15:8];
      pbm_pkg::MODE_SCREEN:  r = ~scr[15:8];
      default:               r = d;
    endcase
  end

endmodule

FILE: rtl/pbm_core.sv
module pbm_core (
  input  pbm_pkg::cfg_t     cfg,
  input  pbm_pkg::in_word_t in_word,
  output logic [31:0]       result_pixel
);

  logic [8:0]  w_sat;
  logic [3:0]  chan_mode;
  logic        is_fill;
  logic [23:0] s_bytes;
  logic [23:0] c_bytes;
  logic        odd_square;

  assign w_sat      = cfg.weight[8] ? pbm_pkg::FULL_WEIGHT : cfg.weight;
  assign is_fill    = (cfg.mode == pbm_pkg::MODE_FILL);
  // fill is a blend against the constant colour
  assign chan_mode  = is_fill ? pbm_pkg::MODE_BLEND : cfg.mode;
  assign s_bytes    = is_fill ? {cfg.fill_red, cfg.fill_green, cfg.fill_blue}
                              : in_word.src_pixel[23:0];
  assign odd_square = in_word.column[0] ^ in_word.row[0];

  for (genvar k = 0; k < 3; k++) begin : g_chan
    pbm_chan u_chan (
      .mode (chan_mode),
      .s    (s_bytes[8*k +: 8]),
      .d    (in_word.dst_pixel[8*k +: 8]),
      .w    (w_sat),
      .r    (c_bytes[8*k +: 8])
    );
  end

  always_comb begin
    case (cfg.mode)
      pbm_pkg::MODE_GLASS: result_pixel = odd_square ? cfg.glass_color : in_word.dst_pixel;
      pbm_pkg::MODE_XOR:   result_pixel = in_word.src_pixel ^ in_word.dst_pixel;
      pbm_pkg::MODE_BLEND,
      pbm_pkg::MODE_FILL,
      pbm_pkg::MODE_DARKEN,
      pbm_pkg::MODE_LIGHTEN,
      pbm_pkg::MODE_DIFF,
      pbm_pkg::MODE_MULT,
      pbm_pkg::MODE_SCREEN: result_pixel = {in_word.dst_pixel[31:24], c_bytes};
      default:              result_pixel = in_word.dst_pixel;
    endcase
  end

endmodule

FILE: rtl/pixel_blend_mode_unit_top.sv
// Channel  | Direction | Handshake         | Payload
// in_      | slave     | tvalid/tready     | tdata 88b: src, dst, column, row
// out_     | master    | tvalid/tready     | tdata 32b: result_pixel
// cfg_     | APB slave | psel/penable      | 6 regs at 4*i, 32-bit data
//
// One word per clock while out_tready is high. An accepted word goes to an
// input register, then through the blend datapath to the output register
// that drives out_tvalid. The output register parts the two sides, so a new
// word is taken while a finished one waits. Reset (rst_n, synchronous)
// empties both stages and loads register defaults (mode blend, weight 256).
// in_tready falls only when both stages are full and out_tready is low.
module pixel_blend_mode_unit_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: src_pixel[31:0], dst_pixel[63:32], column[75:64], row[87:76]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pbm_pkg::IN_W-1:0]   in_tdata,
  // out_tdata: result_pixel[31:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pbm_pkg::OUT_W-1:0]  out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pbm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [pbm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [pbm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  pbm_pkg::cfg_t     cfg;
  pbm_pkg::in_word_t in_word_r;
  logic              in_valid_r;
  logic              in_valid_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [31:0]       out_data_r;
  logic [31:0]       result_pixel;
  logic              out_free;   // output register can take a word this cycle
  logic              in_accept;
  logic              advance;    // input stage moves into the output stage

  pbm_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pbm_core u_core (
    .cfg          (cfg),
    .in_word      (in_word_r),
    .result_pixel (result_pixel)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;
  assign in_accept = in_tvalid && in_tready;

  assign in_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_word_r <= pbm_pkg::in_word_t'(in_tdata);
    end
    if (advance) begin
      out_data_r <= result_pixel;
    end
  end

endmodule

FILE: rtl/pbm_checker.sv
module pbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out word dropped or changed under stall");

  // an accepted word reaches the output through the input and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("accepted word did not reach output");

  // input stalls only behind a waiting output word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind pixel_blend_mode_unit_top pbm_checker u_pbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
